>>> rtl/pmaqi_pkg.sv
`timescale 1ns / 1ps

package pmaqi_pkg;

   localparam int CONC_W     = 16;
   localparam int CX_W       = 20;
   localparam int CLIP_W     = 13;
   localparam int OFF_W      = 11;
   localparam int DEN_W      = 11;
   localparam int DI_W       = 7;
   localparam int IDX_W      = 9;
   localparam int DVD_W      = 19;
   localparam int DSR_W      = DEN_W + 1;
   localparam int QUO_W      = 7;
   localparam int BAND_N     = 7;
   localparam int BAND_IDX_W = 3;
   localparam int LEVEL_W    = 3;

   localparam logic [IDX_W-1:0] INDEX_CAP              = 9'd500;
   localparam logic [IDX_W-1:0] LEVEL_GOOD_MAX         = 9'd50;
   localparam logic [IDX_W-1:0] LEVEL_MODERATE_MAX     = 9'd100;
   localparam logic [IDX_W-1:0] LEVEL_SENSITIVE_MAX    = 9'd150;
   localparam logic [IDX_W-1:0] LEVEL_UNHEALTHY_MAX    = 9'd200;
   localparam logic [IDX_W-1:0] LEVEL_VERY_UNHEALTHY_MAX = 9'd300;

   typedef enum logic {
      POL_FINE   = 1'b0,
      POL_COARSE = 1'b1
   } pollutant_type;

   typedef enum logic [LEVEL_W-1:0] {
      LVL_GOOD           = 3'd0,
      LVL_MODERATE       = 3'd1,
      LVL_SENSITIVE      = 3'd2,
      LVL_UNHEALTHY      = 3'd3,
      LVL_VERY_UNHEALTHY = 3'd4,
      LVL_HAZARDOUS      = 3'd5
   } level_type;

   typedef struct packed {
      logic [CLIP_W-1:0] lo;
      logic [CLIP_W-1:0] hi;
      logic [DEN_W-1:0]  den;
      logic [IDX_W-1:0]  il;
      logic [DI_W-1:0]   di;
   } band_type;

   typedef struct packed {
      logic              tag;
      logic [DVD_W-1:0]  dvd;
      logic [DSR_W-1:0]  dsr;
      logic [IDX_W-1:0]  base;
   } div_req_type;

   typedef struct packed {
      logic              tag;
      logic [IDX_W-1:0]  base;
      logic [QUO_W-1:0]  quo;
   } div_rsp_type;

   // concentration bounds in tenths of ug/m3
   localparam band_type BAND_TBL [2][BAND_N] = '{
      '{
         '{13'd0,    13'd120,  11'd120,  9'd0,   7'd50},
         '{13'd121,  13'd354,  11'd233,  9'd51,  7'd49},
         '{13'd355,  13'd554,  11'd199,  9'd101, 7'd49},
         '{13'd555,  13'd1504, 11'd949,  9'd151, 7'd49},
         '{13'd1505, 13'd2504, 11'd999,  9'd201, 7'd99},
         '{13'd2505, 13'd3504, 11'd999,  9'd301, 7'd99},
         '{13'd3505, 13'd5004, 11'd1499, 9'd401, 7'd99}
      },
      '{
         '{13'd0,    13'd540,  11'd540,  9'd0,   7'd50},
         '{13'd550,  13'd1540, 11'd990,  9'd51,  7'd49},
         '{13'd1550, 13'd2540, 11'd990,  9'd101, 7'd49},
         '{13'd2550, 13'd3540, 11'd990,  9'd151, 7'd49},
         '{13'd3550, 13'd4240, 11'd690,  9'd201, 7'd99},
         '{13'd4250, 13'd5040, 11'd790,  9'd301, 7'd99},
         '{13'd5050, 13'd6040, 11'd990,  9'd401, 7'd99}
      }
   };

endpackage

>>> rtl/pmaqi_div.sv
`timescale 1ns / 1ps

module pmaqi_div
   import pmaqi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  div_req_type in_req,
   output logic        out_valid,
   input  logic        out_ready,
   output div_rsp_type out_rsp
);

   logic [QUO_W-1:0] valid_ff;
   logic [QUO_W:0]   ready;

   logic [DVD_W-1:0] rem_ff  [QUO_W];
   logic [DSR_W-1:0] dsr_ff  [QUO_W];
   logic [IDX_W-1:0] base_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff  [QUO_W];
   logic [QUO_W-1:0] tag_ff;

   logic [QUO_W-1:0] src_valid;
   logic [QUO_W-1:0] src_tag;
   logic [DVD_W-1:0] src_rem  [QUO_W];
   logic [DSR_W-1:0] src_dsr  [QUO_W];
   logic [IDX_W-1:0] src_base [QUO_W];
   logic [QUO_W-1:0] src_quo  [QUO_W];
   logic [DVD_W-1:0] trial    [QUO_W];
   logic [QUO_W-1:0] fits;
   logic [DVD_W-1:0] rem_in   [QUO_W];
   logic [QUO_W-1:0] quo_in   [QUO_W];

   always_comb begin
      ready[QUO_W] = out_ready;
      for (int j = QUO_W - 1; j >= 0; j--) begin
         ready[j] = !valid_ff[j] || ready[j+1];
      end
   end

   assign in_ready = ready[0];

   always_comb begin
      src_valid[0] = in_valid;
      src_tag[0]   = in_req.tag;
      src_rem[0]   = in_req.dvd;
      src_dsr[0]   = in_req.dsr;
      src_base[0]  = in_req.base;
      src_quo[0]   = '0;
      for (int j = 1; j < QUO_W; j++) begin
         src_valid[j] = valid_ff[j-1];
         src_tag[j]   = tag_ff[j-1];
         src_rem[j]   = rem_ff[j-1];
         src_dsr[j]   = dsr_ff[j-1];
         src_base[j]  = base_ff[j-1];
         src_quo[j]   = quo_ff[j-1];
      end
   end

   // one quotient bit per stage, most significant first
   always_comb begin
      for (int j = 0; j < QUO_W; j++) begin
         trial[j]  = DVD_W'(src_dsr[j]) << (QUO_W - 1 - j);
         fits[j]   = src_rem[j] >= trial[j];
         rem_in[j] = fits[j] ? (src_rem[j] - trial[j]) : src_rem[j];
         quo_in[j] = src_quo[j] | (QUO_W'(fits[j]) << (QUO_W - 1 - j));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int j = 0; j < QUO_W; j++) begin
            if (ready[j]) begin
               valid_ff[j] <= src_valid[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QUO_W; j++) begin
         if (ready[j] && src_valid[j]) begin
            rem_ff[j]  <= rem_in[j];
            dsr_ff[j]  <= src_dsr[j];
            base_ff[j] <= src_base[j];
            quo_ff[j]  <= quo_in[j];
            tag_ff[j]  <= src_tag[j];
         end
      end
   end

   assign out_valid    = valid_ff[QUO_W-1];
   assign out_rsp.tag  = tag_ff[QUO_W-1];
   assign out_rsp.base = base_ff[QUO_W-1];
   assign out_rsp.quo  = quo_ff[QUO_W-1];

endmodule

>>> rtl/pmaqi_lane.sv
`timescale 1ns / 1ps

module pmaqi_lane
   import pmaqi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  pollutant_type     sel,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CONC_W-1:0] in_conc,
   input  logic              in_tag,
   output logic              out_valid,
   input  logic              out_ready,
   output div_rsp_type       out_rsp
);

   logic [CX_W-1:0]       conc_x10;
   logic [CLIP_W-1:0]     c_low;
   logic [CLIP_W-1:0]     band_lo;
   logic [CLIP_W-1:0]     diff;

   logic                  s1_top_in;
   logic [BAND_IDX_W-1:0] s1_band_in;
   logic [OFF_W-1:0]      s1_off_in;

   logic                  s1_valid_ff;
   logic                  s1_top_ff;
   logic [BAND_IDX_W-1:0] s1_band_ff;
   logic [OFF_W-1:0]      s1_off_ff;
   logic                  s1_tag_ff;

   band_type              entry;
   logic [DVD_W-1:0]      prod;
   div_req_type           s2_req_in;
   logic                  s2_valid_ff;
   div_req_type           s2_req_ff;

   logic                  s1_ready;
   logic                  s2_ready;
   logic                  div_ready;

   // band search on the concentration in tenths
   always_comb begin
      conc_x10   = ({{(CX_W-CONC_W){1'b0}}, in_conc} << 3)
                 + ({{(CX_W-CONC_W){1'b0}}, in_conc} << 1);
      s1_top_in  = conc_x10 >= CX_W'(BAND_TBL[sel][BAND_N-1].hi);
      s1_band_in = BAND_IDX_W'(BAND_N - 1);
      for (int k = BAND_N - 1; k >= 0; k--) begin
         if (conc_x10 <= CX_W'(BAND_TBL[sel][k].hi)) begin
            s1_band_in = BAND_IDX_W'(k);
         end
      end
      c_low     = conc_x10[CLIP_W-1:0];
      band_lo   = BAND_TBL[sel][s1_band_in].lo;
      diff      = c_low - band_lo;
      s1_off_in = (c_low > band_lo) ? diff[OFF_W-1:0] : '0;
   end

   // dividend 2*di*off + den over divisor 2*den; zero dividend at or above the top bound
   always_comb begin
      entry          = BAND_TBL[sel][s1_band_ff];
      prod           = DVD_W'(entry.di) * DVD_W'(s1_off_ff);
      s2_req_in.tag  = s1_tag_ff;
      s2_req_in.dsr  = {entry.den, 1'b0};
      s2_req_in.dvd  = s1_top_ff ? '0 : ((prod << 1) + DVD_W'(entry.den));
      s2_req_in.base = s1_top_ff ? INDEX_CAP : entry.il;
   end

   assign s2_ready = !s2_valid_ff || div_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_top_ff  <= s1_top_in;
         s1_band_ff <= s1_band_in;
         s1_off_ff  <= s1_off_in;
         s1_tag_ff  <= in_tag;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_req_ff <= s2_req_in;
      end
   end

   pmaqi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_ready  (div_ready),
      .in_req    (s2_req_ff),
      .out_valid (out_valid),
      .out_ready (out_ready),
      .out_rsp   (out_rsp)
   );

endmodule

>>> rtl/pmaqi_merge.sv
`timescale 1ns / 1ps

module pmaqi_merge
   import pmaqi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  div_rsp_type        fine_rsp,
   input  div_rsp_type        coarse_rsp,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [IDX_W-1:0]   rsp_index_pm25,
   output logic [IDX_W-1:0]   rsp_index_pm10,
   output logic [IDX_W-1:0]   rsp_index_overall,
   output logic [LEVEL_W-1:0] rsp_band_level,
   output logic               rsp_index_valid
);

   logic [IDX_W-1:0] fine_in;
   logic [IDX_W-1:0] coarse_in;
   logic [IDX_W-1:0] overall_in;
   level_type        level_in;

   logic             valid_ff;
   logic [IDX_W-1:0] fine_ff;
   logic [IDX_W-1:0] coarse_ff;
   logic [IDX_W-1:0] overall_ff;
   level_type        level_ff;
   logic             flag_ff;

   always_comb begin
      fine_in    = fine_rsp.base + IDX_W'(fine_rsp.quo);
      coarse_in  = coarse_rsp.base + IDX_W'(coarse_rsp.quo);
      overall_in = (fine_in >= coarse_in) ? fine_in : coarse_in;
      priority if (overall_in <= LEVEL_GOOD_MAX) begin
         level_in = LVL_GOOD;
      end else if (overall_in <= LEVEL_MODERATE_MAX) begin
         level_in = LVL_MODERATE;
      end else if (overall_in <= LEVEL_SENSITIVE_MAX) begin
         level_in = LVL_SENSITIVE;
      end else if (overall_in <= LEVEL_UNHEALTHY_MAX) begin
         level_in = LVL_UNHEALTHY;
      end else if (overall_in <= LEVEL_VERY_UNHEALTHY_MAX) begin
         level_in = LVL_VERY_UNHEALTHY;
      end else begin
         level_in = LVL_HAZARDOUS;
      end
   end

   assign in_ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         fine_ff    <= fine_in;
         coarse_ff  <= coarse_in;
         overall_ff <= overall_in;
         level_ff   <= level_in;
         flag_ff    <= fine_rsp.tag;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_index_pm25    = fine_ff;
   assign rsp_index_pm10    = coarse_ff;
   assign rsp_index_overall = overall_ff;
   assign rsp_band_level    = level_ff;
   assign rsp_index_valid   = flag_ff;

endmodule

>>> rtl/pm_aqi_breakpoint_index_top.sv
// Path: an accepted req item passes lane stages s1 and s2, the divider stages and the merge register.
// Throughput: one item per cycle when nothing stalls; both lanes run side by side,
// and each divider resolves one quotient bit per stage over 7 pipelined stages.
// Stalls ripple back stage by stage, so empty stages keep taking items.
// Reset: synchronous, active high; clears every stage valid, no rsp item pending.
`timescale 1ns / 1ps

module pm_aqi_breakpoint_index_top
   import pmaqi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CONC_W-1:0]  req_pm25_conc,
   input  logic [CONC_W-1:0]  req_pm10_conc,
   input  logic               req_sensor_connected,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [IDX_W-1:0]   rsp_index_pm25,
   output logic [IDX_W-1:0]   rsp_index_pm10,
   output logic [IDX_W-1:0]   rsp_index_overall,
   output logic [LEVEL_W-1:0] rsp_band_level,
   output logic               rsp_index_valid
);

   logic        fine_ready;
   logic        coarse_ready;
   logic        fine_valid;
   logic        coarse_valid;
   logic        lane_valid;
   logic        merge_ready;
   div_rsp_type fine_rsp;
   div_rsp_type coarse_rsp;

   assign req_stall  = !(fine_ready && coarse_ready);
   assign lane_valid = req_valid && !req_stall;

   pmaqi_lane u_lane_fine (
      .clock     (clock),
      .reset     (reset),
      .sel       (POL_FINE),
      .in_valid  (lane_valid),
      .in_ready  (fine_ready),
      .in_conc   (req_pm25_conc),
      .in_tag    (req_sensor_connected),
      .out_valid (fine_valid),
      .out_ready (merge_ready && coarse_valid),
      .out_rsp   (fine_rsp)
   );

   pmaqi_lane u_lane_coarse (
      .clock     (clock),
      .reset     (reset),
      .sel       (POL_COARSE),
      .in_valid  (lane_valid),
      .in_ready  (coarse_ready),
      .in_conc   (req_pm10_conc),
      .in_tag    (req_sensor_connected),
      .out_valid (coarse_valid),
      .out_ready (merge_ready && fine_valid),
      .out_rsp   (coarse_rsp)
   );

   pmaqi_merge u_merge (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (fine_valid && coarse_valid),
      .in_ready          (merge_ready),
      .fine_rsp          (fine_rsp),
      .coarse_rsp        (coarse_rsp),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_index_pm25    (rsp_index_pm25),
      .rsp_index_pm10    (rsp_index_pm10),
      .rsp_index_overall (rsp_index_overall),
      .rsp_band_level    (rsp_band_level),
      .rsp_index_valid   (rsp_index_valid)
   );

endmodule

>>> rtl/pmaqi_checker.sv
`timescale 1ns / 1ps

module pmaqi_checker
   import pmaqi_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [CONC_W-1:0]  req_pm25_conc,
   input logic [CONC_W-1:0]  req_pm10_conc,
   input logic               req_sensor_connected,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [IDX_W-1:0]   rsp_index_pm25,
   input logic [IDX_W-1:0]   rsp_index_pm10,
   input logic [IDX_W-1:0]   rsp_index_overall,
   input logic [LEVEL_W-1:0] rsp_band_level,
   input logic               rsp_index_valid
);

   a_overall_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_index_overall ==
         ((rsp_index_pm25 >= rsp_index_pm10) ? rsp_index_pm25 : rsp_index_pm10))
      else $error("overall index is not the larger lane index");

   a_index_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_index_pm25 <= INDEX_CAP) && (rsp_index_pm10 <= INDEX_CAP))
      else $error("lane index above cap");

   a_level_good: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_index_overall <= LEVEL_GOOD_MAX) == (rsp_band_level == LVL_GOOD)))
      else $error("band level disagrees with overall index");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_index_overall)
         && $stable(rsp_index_valid))
      else $error("stalled rsp item changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp item after reset");

endmodule

bind pm_aqi_breakpoint_index_top pmaqi_checker u_checker (.*);
